// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checked sequencer module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle or sequence check on i_clk, off while i_rst_n is low
`define CHK_PROP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Next-cycle check: ante in one cycle implies cons in the following one
`define CHK_NEXT(label, ante, cons, msg) \
    `CHK_PROP(label, (ante) |=> (cons), msg)

`endif

// ----- hdl/stq_pkg.sv -----
// Shared types, constants and node merge function for the subarray query block
package stq_pkg;

    localparam int MAX_LEN    = 16384;
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int NODE_DEPTH = 2 * MAX_LEN + 1;
    localparam int ADDR_W     = $clog2(NODE_DEPTH);
    localparam int VAL_W      = 16;
    localparam int OUT_W      = 31;
    localparam int FIN_W      = 35;
    localparam int RES_CNT    = 5;
    localparam int RIDX_W     = 3;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_REBUILD = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    localparam logic [RIDX_W-1:0] DISJ_LAST = RIDX_W'(2);
    localparam logic [RIDX_W-1:0] OVL_LAST  = RIDX_W'(4);

    localparam logic signed [31:0] SENTINEL = -32'sd1073741824;
    localparam logic signed [FIN_W-1:0] ANS_MAX = FIN_W'(64'sd1073741823);
    localparam logic signed [FIN_W-1:0] ANS_MIN = FIN_W'(-64'sd1073741824);

    typedef struct packed {
        logic signed [31:0] sum;
        logic signed [31:0] best;
        logic signed [31:0] pre;
        logic signed [31:0] suf;
    } t_node;

    localparam t_node NODE_ZERO  = '{sum: '0, best: '0, pre: '0, suf: '0};
    localparam t_node NODE_IDENT = '{sum: '0, best: SENTINEL, pre: SENTINEL, suf: SENTINEL};

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_RB_TEST,
        ST_RB_RD0,
        ST_RB_RD1,
        ST_RB_WR,
        ST_RG_INIT,
        ST_RG_TEST,
        ST_RG_LW,
        ST_RG_RCHK,
        ST_RG_RW,
        ST_RG_STORE,
        ST_FIN1,
        ST_FIN2
    } t_state;

    typedef struct packed {
        logic ld_in;
        logic clr_wr;
        logic leaf_wr;
        logic rb_init;
        logic rb_rd0;
        logic rb_rd1;
        logic rb_wr;
        logic q_start;
        logic rg_init;
        logic rg_rdl;
        logic rg_lmrg;
        logic rg_rdr;
        logic rg_rmrg;
        logic rg_shift;
        logic rg_store;
        logic fin1;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] op;
        logic       bad;
        logic       rb_done;
        logic       l_lt_r;
        logic       l_odd;
        logic       r_odd;
        logic       last_range;
        logic       out_free;
    } t_sts;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v > 33'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -33'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [32:0] max33(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_node node_merge(input t_node a, input t_node b);
        t_node m;
        m.sum  = sat32(33'(a.sum) + 33'(b.sum));
        m.best = sat32(max33(max33(33'(a.best), 33'(b.best)), 33'(a.suf) + 33'(b.pre)));
        m.pre  = sat32(max33(33'(a.pre), 33'(a.sum) + 33'(b.pre)));
        m.suf  = sat32(max33(33'(b.suf), 33'(b.sum) + 33'(a.suf)));
        return m;
    endfunction

endpackage

// ----- hdl/stq_ctrl.sv -----
// Sequencer for clear, leaf write, rebuild and range walks
`include "assert_macros.svh"

module stq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  stq_pkg::t_sts i_sts,
    output stq_pkg::t_cmd o_cmd
);

    stq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stq_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            stq_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) n_state = stq_pkg::ST_IDLE;
            end
            stq_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = stq_pkg::ST_DECODE;
            end
            stq_pkg::ST_DECODE: begin
                case (i_sts.op)
                    stq_pkg::OP_REBUILD: n_state = stq_pkg::ST_RB_TEST;
                    stq_pkg::OP_QUERY: begin
                        n_state = i_sts.bad ? stq_pkg::ST_FIN2 : stq_pkg::ST_RG_INIT;
                    end
                    default: n_state = stq_pkg::ST_IDLE;
                endcase
            end
            stq_pkg::ST_RB_TEST: begin
                n_state = i_sts.rb_done ? stq_pkg::ST_IDLE : stq_pkg::ST_RB_RD0;
            end
            stq_pkg::ST_RB_RD0:  n_state = stq_pkg::ST_RB_RD1;
            stq_pkg::ST_RB_RD1:  n_state = stq_pkg::ST_RB_WR;
            stq_pkg::ST_RB_WR:   n_state = stq_pkg::ST_RB_TEST;
            stq_pkg::ST_RG_INIT: n_state = stq_pkg::ST_RG_TEST;
            stq_pkg::ST_RG_TEST: begin
                if (!i_sts.l_lt_r) begin
                    n_state = stq_pkg::ST_RG_STORE;
                end else if (i_sts.l_odd) begin
                    n_state = stq_pkg::ST_RG_LW;
                end else begin
                    n_state = stq_pkg::ST_RG_RCHK;
                end
            end
            stq_pkg::ST_RG_LW: n_state = stq_pkg::ST_RG_RCHK;
            stq_pkg::ST_RG_RCHK: begin
                n_state = i_sts.r_odd ? stq_pkg::ST_RG_RW : stq_pkg::ST_RG_TEST;
            end
            stq_pkg::ST_RG_RW: n_state = stq_pkg::ST_RG_TEST;
            stq_pkg::ST_RG_STORE: begin
                n_state = i_sts.last_range ? stq_pkg::ST_FIN1 : stq_pkg::ST_RG_INIT;
            end
            stq_pkg::ST_FIN1: n_state = stq_pkg::ST_FIN2;
            stq_pkg::ST_FIN2: begin
                if (i_sts.out_free) n_state = stq_pkg::ST_IDLE;
            end
            default: n_state = stq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            stq_pkg::ST_CLEAR: o_cmd.clr_wr = 1'b1;
            stq_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.ld_in  = i_in_valid;
            end
            stq_pkg::ST_DECODE: begin
                case (i_sts.op)
                    stq_pkg::OP_WRITE:   o_cmd.leaf_wr = 1'b1;
                    stq_pkg::OP_REBUILD: o_cmd.rb_init = 1'b1;
                    stq_pkg::OP_QUERY:   o_cmd.q_start = 1'b1;
                    default: ;
                endcase
            end
            stq_pkg::ST_RB_RD0:  o_cmd.rb_rd0  = 1'b1;
            stq_pkg::ST_RB_RD1:  o_cmd.rb_rd1  = 1'b1;
            stq_pkg::ST_RB_WR:   o_cmd.rb_wr   = 1'b1;
            stq_pkg::ST_RG_INIT: o_cmd.rg_init = 1'b1;
            stq_pkg::ST_RG_TEST: begin
                o_cmd.rg_rdl = i_sts.l_lt_r & i_sts.l_odd;
            end
            stq_pkg::ST_RG_LW: o_cmd.rg_lmrg = 1'b1;
            stq_pkg::ST_RG_RCHK: begin
                o_cmd.rg_rdr   = i_sts.r_odd;
                o_cmd.rg_shift = ~i_sts.r_odd;
            end
            stq_pkg::ST_RG_RW: begin
                o_cmd.rg_rmrg  = 1'b1;
                o_cmd.rg_shift = 1'b1;
            end
            stq_pkg::ST_RG_STORE: o_cmd.rg_store = 1'b1;
            stq_pkg::ST_FIN1:     o_cmd.fin1     = 1'b1;
            stq_pkg::ST_FIN2:     o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

    `CHK_NEXT(a_accept_decode, i_in_valid && o_in_ready, r_state == stq_pkg::ST_DECODE,
        "accepted beat not decoded")
    `CHK_PROP(a_load_free, o_cmd.out_load |-> i_sts.out_free,
        "result loaded over a pending beat")
    `CHK_NEXT(a_clear_hold, r_state == stq_pkg::ST_CLEAR && !i_sts.clr_last,
        r_state == stq_pkg::ST_CLEAR, "clear pass left early")

endmodule

// ----- hdl/stq_datapath.sv -----
// Node memory, range walker, rebuild and answer arithmetic
module stq_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  stq_pkg::t_cmd                  i_cmd,
    output stq_pkg::t_sts                  o_sts,
    input  logic [95:0]                    i_in_data,
    input  logic [1:0]                     i_in_user,
    input  logic                           i_cfg_valid,
    input  logic [stq_pkg::LEN_W-1:0]      i_cfg_data,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic signed [stq_pkg::OUT_W-1:0] o_best_sum,
    output logic                           o_bad_query
);

    localparam int AW = stq_pkg::ADDR_W;
    localparam int LW = stq_pkg::LEN_W;
    localparam int FW = stq_pkg::FIN_W;

    stq_pkg::t_node mem [stq_pkg::NODE_DEPTH];
    stq_pkg::t_node r_rdata;

    logic [LW-1:0]                r_len;
    logic [AW-1:0]                r_clr;
    logic [1:0]                   r_op;
    logic [LW-1:0]                r_pos, r_x1, r_y1, r_x2, r_y2;
    logic signed [stq_pkg::VAL_W-1:0] r_val;
    logic [LW-1:0]                r_k;
    stq_pkg::t_node               r_a, r_left, r_right;
    logic [AW-1:0]                r_l, r_r;
    logic                         r_empty;
    logic [stq_pkg::RIDX_W-1:0]   r_ridx;
    stq_pkg::t_node               r_res [stq_pkg::RES_CNT];
    logic signed [FW-1:0]         r_t0, r_t1, r_t2;
    logic                         r_out_valid;
    logic signed [stq_pkg::OUT_W-1:0] r_best;
    logic                         r_bad;

    logic                         we;
    logic [AW-1:0]                waddr, raddr;
    stq_pkg::t_node               wdata;
    logic                         disj, bad, pos_ok;
    logic [LW-1:0]                lo, hi;
    logic [LW-1:0]                n_len;
    logic signed [FW-1:0]         ovl1, ovl3, fin_v, fin_c;

    function automatic logic signed [stq_pkg::OUT_W-1:0] pick_best(
        input logic b, input logic signed [FW-1:0] v);
        return b ? '0 : v[stq_pkg::OUT_W-1:0];
    endfunction

    // configuration: zero maps to one, large values clip to MAX_LEN
    always_comb begin
        n_len = i_cfg_data;
        if (i_cfg_data == '0) begin
            n_len = LW'(1);
        end else if (i_cfg_data > LW'(stq_pkg::MAX_LEN)) begin
            n_len = LW'(stq_pkg::MAX_LEN);
        end
    end

    assign disj   = r_y1 < r_x2;
    assign pos_ok = (r_pos != '0) && (r_pos <= r_len);
    assign bad    = (r_x1 > r_y1) || (r_x2 > r_y2) || (r_x1 > r_x2) || (r_y1 > r_y2) ||
                    (r_x1 == '0) || (r_y2 > r_len);

    // range bounds for the current walk
    always_comb begin
        lo = r_x1;
        hi = r_y1;
        case (r_ridx)
            3'd0: begin
                lo = disj ? r_x1 : r_x2;
                hi = r_y1;
            end
            3'd1: begin
                lo = disj ? r_y1 + LW'(1) : r_x1;
                hi = r_x2 - LW'(1);
            end
            3'd2: begin
                lo = r_x2;
                hi = r_y2;
            end
            3'd3: begin
                lo = r_y1 + LW'(1);
                hi = r_y2;
            end
            default: begin
                lo = r_x1;
                hi = r_y1;
            end
        endcase
    end

    // memory port selection
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = stq_pkg::NODE_ZERO;
        raddr = '0;
        if (i_cmd.clr_wr) begin
            we    = 1'b1;
            waddr = r_clr;
        end else if (i_cmd.leaf_wr) begin
            we    = pos_ok;
            waddr = AW'(r_pos) + AW'(r_len);
            wdata = '{sum: 32'(r_val), best: 32'(r_val), pre: 32'(r_val), suf: 32'(r_val)};
        end else if (i_cmd.rb_wr) begin
            we    = 1'b1;
            waddr = AW'(r_k);
            wdata = stq_pkg::node_merge(r_a, r_rdata);
        end
        if (i_cmd.rb_rd0) begin
            raddr = {AW'(r_k)} << 1;
        end else if (i_cmd.rb_rd1) begin
            raddr = ({AW'(r_k)} << 1) | AW'(1);
        end else if (i_cmd.rg_rdl) begin
            raddr = r_l;
        end else if (i_cmd.rg_rdr) begin
            raddr = r_r - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rdata <= mem[raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LW'(1);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_len <= n_len;
            if (i_cmd.clr_wr) r_clr <= r_clr + AW'(1);
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_op  <= i_in_user;
            r_pos <= i_in_data[14:0];
            r_val <= i_in_data[30:15];
            r_x1  <= i_in_data[45:31];
            r_y1  <= i_in_data[60:46];
            r_x2  <= i_in_data[75:61];
            r_y2  <= i_in_data[90:76];
        end
        if (i_cmd.rb_init) begin
            r_k <= r_len - LW'(1);
        end else if (i_cmd.rb_wr) begin
            r_k <= r_k - LW'(1);
        end
        if (i_cmd.rb_rd1) r_a <= r_rdata;
        if (i_cmd.q_start) begin
            r_ridx <= '0;
        end else if (i_cmd.rg_store) begin
            r_ridx <= r_ridx + stq_pkg::RIDX_W'(1);
        end
        if (i_cmd.rg_init) begin
            r_l     <= AW'(lo) + AW'(r_len);
            r_r     <= AW'(hi) + AW'(r_len) + AW'(1);
            r_empty <= lo > hi;
            r_left  <= stq_pkg::NODE_IDENT;
            r_right <= stq_pkg::NODE_IDENT;
        end else begin
            if (i_cmd.rg_lmrg) begin
                r_left <= stq_pkg::node_merge(r_left, r_rdata);
                r_l    <= r_l + AW'(1);
            end
            if (i_cmd.rg_rmrg) r_right <= stq_pkg::node_merge(r_rdata, r_right);
            if (i_cmd.rg_rdr) r_r <= r_r - AW'(1);
            if (i_cmd.rg_shift) begin
                r_l <= r_l >> 1;
                r_r <= r_r >> 1;
            end
        end
        if (i_cmd.rg_store) begin
            r_res[r_ridx] <= r_empty ? stq_pkg::NODE_ZERO
                                     : stq_pkg::node_merge(r_left, r_right);
        end
        if (i_cmd.fin1) begin
            if (disj) begin
                r_t0 <= FW'(r_res[0].suf) + FW'(r_res[1].sum);
                r_t1 <= FW'(r_res[2].pre);
                r_t2 <= '0;
            end else begin
                r_t0 <= FW'(r_res[0].best);
                r_t1 <= ovl1;
                r_t2 <= ovl3;
            end
        end
        if (i_cmd.out_load) begin
            r_best <= pick_best(bad, fin_c);
            r_bad  <= bad;
        end
    end

    // overlapping windows: clip the side pieces at zero before adding
    always_comb begin
        ovl1 = ((r_res[1].suf > 0) ? FW'(r_res[1].suf) : '0) + FW'(r_res[2].pre);
        ovl3 = FW'(r_res[4].suf) + ((r_res[3].pre > 0) ? FW'(r_res[3].pre) : '0);
    end

    always_comb begin
        if (disj) begin
            fin_v = r_t0 + r_t1;
        end else begin
            fin_v = (r_t0 > r_t1) ? r_t0 : r_t1;
            if (r_t2 > fin_v) fin_v = r_t2;
        end
        fin_c = fin_v;
        if (fin_v > stq_pkg::ANS_MAX) begin
            fin_c = stq_pkg::ANS_MAX;
        end else if (fin_v < stq_pkg::ANS_MIN) begin
            fin_c = stq_pkg::ANS_MIN;
        end
    end

    assign o_sts.clr_last   = r_clr == AW'(stq_pkg::NODE_DEPTH - 1);
    assign o_sts.op         = r_op;
    assign o_sts.bad        = bad;
    assign o_sts.rb_done    = r_k == '0;
    assign o_sts.l_lt_r     = r_l < r_r;
    assign o_sts.l_odd      = r_l[0];
    assign o_sts.r_odd      = r_r[0];
    assign o_sts.last_range = r_ridx == (disj ? stq_pkg::DISJ_LAST : stq_pkg::OVL_LAST);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_best_sum  = r_best;
    assign o_bad_query = r_bad;

endmodule

// ----- hdl/segment_tree_max_subarray_query.sv -----
// Top level: maximum subarray sum queries over a segment tree
//
//  channel   | direction | beat contents
//  ----------+-----------+-------------------------------------------------
//  s_axis    | in        | tuser op; tdata position, value, x1, y1, x2, y2
//  m_axis    | out       | tdata best_sum; tuser bad_query
//  cfg       | in        | length, always accepted
//
// After reset a clear pass zeroes all 32769 tree nodes, one per cycle; no
// beat is taken until it ends. A write is accepted and decoded; a rebuild
// runs, per internal node, a loop test, two child reads on the single node
// read port and the write-back. A query is accepted and decoded, walks
// three or five ranges one tree level at a time and then forms the final
// sum; a rejected query goes from decode straight to the output register.
// A finished result waits in the output register while the next beat is taken.
module segment_tree_max_subarray_query (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // position[14:0], value[30:15], start_low[45:31], start_high[60:46],
    // end_low[75:61], end_high[90:76]
    input  logic [95:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // best_sum[30:0]
    output logic [31:0] m_axis_tdata,
    // bad_query[0]
    output logic [0:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [14:0] i_cfg_data
);

    stq_pkg::t_cmd cmd;
    stq_pkg::t_sts sts;
    logic signed [stq_pkg::OUT_W-1:0] best_sum;
    logic bad_query;

    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    stq_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_best_sum  (best_sum),
        .o_bad_query (bad_query)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {1'b0, best_sum};
    assign m_axis_tuser = bad_query;

endmodule

// ----- verif/segment_tree_max_subarray_query_test.sv -----
// Testbench for the segment tree maximum subarray query block: directed and random beats
`timescale 1ns / 100ps

module segment_tree_max_subarray_query_test;

    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int NODE_SLOTS = 2 * stq_pkg::MAX_LEN + 2;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        int sum;
        int best;
        int pre;
        int suf;
    } t_seg_cell;

    typedef struct {
        logic [31:0] sum_bits;
        logic        bad;
    } t_query_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [14:0] i_cfg_data = '0;

    segment_tree_max_subarray_query dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    t_seg_cell     cells[NODE_SLOTS];
    int            cur_len = 1;
    t_query_answer answers_due[$];
    int            errors = 0;
    int            cycles = 0;
    bit            no_idle = 0;
    int            rdy_hold = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("segment_tree_max_subarray_query_test: done, errors");
            $finish;
        end
    end

    // Predictor
    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return int'(v);
    endfunction

    function automatic longint lmax(longint a, longint b);
        return a > b ? a : b;
    endfunction

    function automatic t_seg_cell join_cells(t_seg_cell a, t_seg_cell b);
        t_seg_cell m;
        m.sum  = clamp32(longint'(a.sum) + b.sum);
        m.best = clamp32(lmax(lmax(a.best, b.best), longint'(a.suf) + b.pre));
        m.pre  = clamp32(lmax(a.pre, longint'(a.sum) + b.pre));
        m.suf  = clamp32(lmax(b.suf, longint'(b.sum) + a.suf));
        return m;
    endfunction

    function automatic t_seg_cell span_agg(int lo, int hi);
        t_seg_cell lft, rgt, zero;
        int l, r;
        zero = '{0, 0, 0, 0};
        if (lo > hi) return zero;
        lft = '{0, -1073741824, -1073741824, -1073741824};
        rgt = lft;
        l = lo + cur_len;
        r = hi + 1 + cur_len;
        while (l < r) begin
            if (l & 1) begin
                lft = join_cells(lft, cells[l]);
                l++;
            end
            if (r & 1) begin
                r--;
                rgt = join_cells(cells[r], rgt);
            end
            l >>= 1;
            r >>= 1;
        end
        return join_cells(lft, rgt);
    endfunction

    function automatic longint best_window(int x1, int y1, int x2, int y2);
        longint res, x;
        t_seg_cell ca, cb, cc, cd, ce;
        if (y1 < x2) begin
            ca = span_agg(x1, y1);
            cb = span_agg(y1 + 1, x2 - 1);
            cc = span_agg(x2, y2);
            res = longint'(ca.suf) + cb.sum + cc.pre;
        end else begin
            ca = span_agg(x2, y1);
            cb = span_agg(x1, x2 - 1);
            cc = span_agg(x2, y2);
            cd = span_agg(y1 + 1, y2);
            ce = span_agg(x1, y1);
            res = ca.best;
            x = lmax(cb.suf, 0);
            res = lmax(res, x + cc.pre);
            x = lmax(cd.pre, 0);
            res = lmax(res, longint'(ce.suf) + x);
        end
        if (res > 1073741823) res = 1073741823;
        if (res < -1073741824) res = -1073741824;
        return res;
    endfunction

    function automatic void predict_beat(logic [1:0] op, logic [14:0] pos,
                                         logic signed [15:0] val, logic [14:0] x1,
                                         logic [14:0] y1, logic [14:0] x2, logic [14:0] y2);
        t_query_answer qa;
        longint ans;
        case (op)
            stq_pkg::OP_WRITE: begin
                if (pos >= 1 && pos <= cur_len)
                    cells[int'(pos) + cur_len] = '{int'(val), int'(val), int'(val), int'(val)};
            end
            stq_pkg::OP_REBUILD: begin
                for (int k = cur_len - 1; k >= 1; k--)
                    cells[k] = join_cells(cells[2 * k], cells[2 * k + 1]);
            end
            stq_pkg::OP_QUERY: begin
                if (x1 > y1 || x2 > y2 || x1 > x2 || y1 > y2 || x1 == 0 || y2 > cur_len) begin
                    qa.sum_bits = '0;
                    qa.bad = 1'b1;
                end else begin
                    ans = best_window(int'(x1), int'(y1), int'(x2), int'(y2));
                    qa.sum_bits = {1'b0, ans[30:0]};
                    qa.bad = 1'b0;
                end
                answers_due.push_back(qa);
            end
            default: ;
        endcase
    endfunction

    // Result side: random stalls, check each beat against the oldest answer
    always @(posedge i_clk) begin
        t_query_answer qa;
        int hold;
        hold = rdy_hold;
        if (m_axis_tvalid && m_axis_tready) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual sum %h bad %b",
                         $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                qa = answers_due.pop_front();
                if (m_axis_tdata !== qa.sum_bits) begin
                    $display("%0t: best_sum mismatch, expected %h actual %h",
                             $time, qa.sum_bits, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser[0] !== qa.bad) begin
                    $display("%0t: bad_query mismatch, expected %b actual %b",
                             $time, qa.bad, m_axis_tuser[0]);
                    errors++;
                end
            end
            hold = no_idle ? 0 : $urandom_range(0, 8);
        end else if (hold > 0) begin
            hold--;
        end
        rdy_hold <= hold;
        m_axis_tready <= i_rst_n && (hold == 0);
    end

    // Send one beat; valid stays high across back-to-back beats
    task automatic send_beat(logic [1:0] op, logic [14:0] pos, logic [15:0] val,
                             logic [14:0] x1, logic [14:0] y1, logic [14:0] x2,
                             logic [14:0] y2);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {5'd0, y2, x2, y1, x1, val, pos};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_beat(op, pos, val, x1, y1, x2, y2);
    endtask

    task automatic send_query(int x1, int y1, int x2, int y2);
        send_beat(stq_pkg::OP_QUERY, 15'($urandom), 16'($urandom),
                  15'(x1), 15'(y1), 15'(x2), 15'(y2));
    endtask

    task automatic send_write(int pos, int val);
        send_beat(stq_pkg::OP_WRITE, 15'(pos), 16'(val), 15'($urandom), 15'($urandom),
                  15'($urandom), 15'($urandom));
    endtask

    task automatic send_rebuild();
        send_beat(stq_pkg::OP_REBUILD, 15'($urandom), 16'($urandom), 15'($urandom),
                  15'($urandom), 15'($urandom), 15'($urandom));
    endtask

    // Hold until all answers are out and any trailing rebuild has finished
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (4 * cur_len + 300) @(posedge i_clk);
    endtask

    task automatic set_length(int v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= 15'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_len = (v == 0) ? 1 : (v > stq_pkg::MAX_LEN ? stq_pkg::MAX_LEN : v);
    endtask

    task automatic test_reset_state();
        send_query(1, 1, 1, 1);
        send_beat(OP_IGNORED, '1, '1, '1, '1, '1, '1);
    endtask

    task automatic test_directed_ops();
        set_length(5);
        send_write(1, 16'h7FFF);
        send_write(2, 16'h8000);
        send_write(3, 16'h7FFF);
        send_write(4, 5);
        send_write(5, 16'hFFFF);
        send_write(0, 123);
        send_write(6, 77);
        send_rebuild();
        send_query(1, 2, 4, 5);
        send_query(1, 2, 3, 5);
        send_query(1, 3, 2, 5);
        send_query(2, 3, 2, 3);
    endtask

    task automatic test_bad_bounds();
        send_query(3, 2, 4, 5);
        send_query(1, 2, 4, 3);
        send_query(3, 3, 2, 4);
        send_query(1, 4, 2, 3);
        send_query(0, 1, 1, 2);
        send_query(1, 2, 3, 6);
    endtask

    task automatic test_length_limits();
        set_length(0);
        send_query(1, 1, 1, 1);
        set_length(20000);
        set_length(16'h7FFF);
        send_write(stq_pkg::MAX_LEN, 16'h8000);
        send_write(1, 16'h7FFF);
        send_rebuild();
        send_query(1, stq_pkg::MAX_LEN, 1, stq_pkg::MAX_LEN);
        send_query(1, 1, stq_pkg::MAX_LEN, stq_pkg::MAX_LEN);
    endtask

    task automatic random_query(int len);
        int x1, y1, x2, y2, t;
        x1 = $urandom_range(1, len);
        y1 = $urandom_range(1, len);
        if (x1 > y1) begin
            t = x1; x1 = y1; y1 = t;
        end
        x2 = $urandom_range(x1, len);
        y2 = $urandom_range((x2 > y1) ? x2 : y1, len);
        send_query(x1, y1, x2, y2);
    endtask

    task automatic test_random();
        int sent, len, pick, n;
        sent = 0;
        while (sent < 1300) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) len = 1;
            else if (pick == 1) len = 64;
            else if (pick == 2) len = 2;
            else len = $urandom_range(3, 40);
            set_length(len);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int p = 1; p <= len; p++) begin
                pick = $urandom_range(0, 9);
                send_write(p, pick == 0 ? 16'h7FFF : (pick == 1 ? 16'h8000 : $urandom));
                sent++;
            end
            send_rebuild();
            sent++;
            n = $urandom_range(10, 40);
            for (int i = 0; i < n; i++) begin
                pick = $urandom_range(0, 19);
                if (pick < 13) begin
                    random_query(len);
                end else if (pick < 15) begin
                    send_write($urandom_range(0, len + 2), $urandom);
                end else if (pick == 15) begin
                    send_rebuild();
                end else if (pick == 16) begin
                    send_query($urandom_range(0, len + 2), $urandom_range(0, len + 2),
                               $urandom_range(0, len + 2), $urandom_range(0, len + 2));
                end else if (pick == 17) begin
                    send_beat(2'($urandom_range(0, 3)), 15'($urandom), 16'($urandom),
                              15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom));
                end else begin
                    // hold off until every answer has come back
                    s_axis_tvalid <= 1'b0;
                    while (answers_due.size() != 0) @(posedge i_clk);
                    random_query(len);
                end
                sent++;
            end
        end
        no_idle = 0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed_ops();
        test_bad_bounds();
        test_length_limits();
        test_random();
        drain();
        if (errors == 0) begin
            $display("segment_tree_max_subarray_query_test: done, clean");
        end else begin
            $display("segment_tree_max_subarray_query_test: done, errors");
        end
        $finish;
    end

endmodule
